FILE: rtl/dmc_pkg.sv
`timescale 1ns / 1ps

package dmc_pkg;

  // default grid size
  localparam int GRID_COLUMNS_DEF = 50;
  localparam int GRID_ROWS_DEF    = 30;

  // fixed field widths on the ports
  localparam int CELL_PORT_W = 11;
  localparam int RND_W       = 16;
  localparam int DIR_W       = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // request kinds
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_STEP    = 1'b1;

  // wall directions
  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START,
    ST_TOP_RD,
    ST_TOP_LATCH,
    ST_PROBE,
    ST_SETTLE,
    ST_PICK,
    ST_RESULT
  } dmc_state_t;

  // visited map access
  typedef struct packed {
    logic rd;
    logic wr;
    logic wbit;
  } vis_ctl_t;

  // path stack operation
  typedef struct packed {
    logic rd;
    logic push;
    logic pop;
    logic restart;
  } stk_ctl_t;

endpackage

FILE: rtl/dfs_maze_carver_top.sv
`timescale 1ns / 1ps
// restart: clears the visited map one cell a cycle, then seeds the start cell, then loads
//   the result
// step: for each stack entry inspected, top read, latch, up to four visited reads on the single
//   port, settle and pick; a step with no maze in progress goes straight to its result
// one request at a time; the next is taken from the cycle after the result loads, even if it waits
// reset: start_cell 0, stack empty, no maze in progress; the map is cleared on restart

module dfs_maze_carver_top #(
  parameter int GRID_COLUMNS = dmc_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = dmc_pkg::GRID_ROWS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dmc_pkg::IN_TDATA_W-1:0]     in_tdata,   // random_value
  input  logic [0:0]                         in_tuser,   // kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dmc_pkg::OUT_TDATA_W-1:0]    out_tdata,  // from_cell, direction, to_cell
  output logic [1:0]                         out_tuser,  // edge_valid, finished
  input  logic                               cfg_we,
  input  logic [dmc_pkg::CELL_PORT_W-1:0]    cfg_wdata   // start_cell
);

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
  localparam int ENTRY_W    = IDX_W + $clog2(GRID_COLUMNS) + $clog2(GRID_ROWS);

  dmc_pkg::vis_ctl_t  vis_ctl;
  logic [IDX_W-1:0]   vis_addr;
  logic               vis_rdata;
  dmc_pkg::stk_ctl_t  stk_ctl;
  logic [ENTRY_W-1:0] stk_wentry;
  logic [ENTRY_W-1:0] stk_rentry;
  logic [DEPTH_W-1:0] stk_depth;

  // sequencer and result register
  dmc_walker #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .ENTRY_W      (ENTRY_W)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .vis_ctl    (vis_ctl),
    .vis_addr   (vis_addr),
    .vis_rdata  (vis_rdata),
    .stk_ctl    (stk_ctl),
    .stk_wentry (stk_wentry),
    .stk_rentry (stk_rentry),
    .stk_depth  (stk_depth)
  );

  // one visited bit per cell
  dmc_visited_map #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS)
  ) u_visited (
    .clk   (clk),
    .ctl   (vis_ctl),
    .addr  (vis_addr),
    .rdata (vis_rdata)
  );

  // backtracking path
  dmc_path_stack #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .ENTRY_W      (ENTRY_W)
  ) u_stack (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (stk_ctl),
    .wentry (stk_wentry),
    .rentry (stk_rentry),
    .depth  (stk_depth)
  );

endmodule

FILE: rtl/dmc_visited_map.sv
`timescale 1ns / 1ps

module dmc_visited_map #(
  parameter int GRID_COLUMNS = dmc_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = dmc_pkg::GRID_ROWS_DEF
) (
  input  logic                                    clk,
  input  dmc_pkg::vis_ctl_t                       ctl,
  input  logic [$clog2(GRID_COLUMNS*GRID_ROWS)-1:0] addr,
  output logic                                    rdata
);

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;

  logic vis_mem [CELL_COUNT];
  logic rdata_r;

  // single port, one read or write per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      vis_mem[addr] <= ctl.wbit;
    end
    if (ctl.rd) begin
      rdata_r <= vis_mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/dmc_path_stack.sv
`timescale 1ns / 1ps

module dmc_path_stack #(
  parameter int GRID_COLUMNS = dmc_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = dmc_pkg::GRID_ROWS_DEF,
  parameter int ENTRY_W      = $clog2(GRID_COLUMNS*GRID_ROWS) + $clog2(GRID_COLUMNS)
                               + $clog2(GRID_ROWS)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  dmc_pkg::stk_ctl_t                           ctl,
  input  logic [ENTRY_W-1:0]                          wentry,
  output logic [ENTRY_W-1:0]                          rentry,
  output logic [$clog2(GRID_COLUMNS*GRID_ROWS+1)-1:0] depth
);

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);

  logic [ENTRY_W-1:0] stk_mem [CELL_COUNT];
  logic [ENTRY_W-1:0] rentry_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [DEPTH_W-1:0] depth_m1;
  logic               not_full;

  assign depth_m1 = depth_r - DEPTH_W'(1);
  assign not_full = (depth_r < DEPTH_W'(CELL_COUNT));

  // stack memory: one write and one top read
  always_ff @(posedge clk) begin
    if (ctl.restart) begin
      stk_mem[IDX_W'(0)] <= wentry;
    end else if (ctl.push && not_full) begin
      stk_mem[depth_r[IDX_W-1:0]] <= wentry;
    end
    if (ctl.rd) begin
      rentry_r <= stk_mem[depth_m1[IDX_W-1:0]];
    end
  end

  // depth counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (ctl.restart) begin
      depth_r <= DEPTH_W'(1);
    end else if (ctl.push && not_full) begin
      depth_r <= depth_r + DEPTH_W'(1);
    end else if (ctl.pop) begin
      depth_r <= depth_m1;
    end
  end

  assign rentry = rentry_r;
  assign depth  = depth_r;

  // a push only follows a new cell, so the stack never overflows
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> not_full)
    else $error("push at full stack");

  // pops only happen on a stack with entries
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> depth_r != '0)
    else $error("pop on empty stack");

  // the top read always addresses a written entry
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd |-> depth_r != '0)
    else $error("top read on empty stack");

endmodule

FILE: rtl/dmc_walker.sv
`timescale 1ns / 1ps

module dmc_walker #(
  parameter int GRID_COLUMNS = dmc_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = dmc_pkg::GRID_ROWS_DEF,
  parameter int ENTRY_W      = $clog2(GRID_COLUMNS*GRID_ROWS) + $clog2(GRID_COLUMNS)
                               + $clog2(GRID_ROWS)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  // request side
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  input  logic [dmc_pkg::IN_TDATA_W-1:0]              in_tdata,
  input  logic                                        in_tuser,
  // result side
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  output logic [dmc_pkg::OUT_TDATA_W-1:0]             out_tdata,
  output logic [1:0]                                  out_tuser,
  // start cell register
  input  logic                                        cfg_we,
  input  logic [dmc_pkg::CELL_PORT_W-1:0]             cfg_wdata,
  // visited map
  output dmc_pkg::vis_ctl_t                           vis_ctl,
  output logic [$clog2(GRID_COLUMNS*GRID_ROWS)-1:0]   vis_addr,
  input  logic                                        vis_rdata,
  // path stack
  output dmc_pkg::stk_ctl_t                           stk_ctl,
  output logic [ENTRY_W-1:0]                          stk_wentry,
  input  logic [ENTRY_W-1:0]                          stk_rentry,
  input  logic [$clog2(GRID_COLUMNS*GRID_ROWS+1)-1:0] stk_depth
);

  localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS;
  localparam int IDX_W      = $clog2(CELL_COUNT);
  localparam int DEPTH_W    = $clog2(CELL_COUNT + 1);
  localparam int COL_W      = $clog2(GRID_COLUMNS);
  localparam int ROW_W      = $clog2(GRID_ROWS);
  localparam int CP_W       = dmc_pkg::CELL_PORT_W;
  localparam int CMP_W      = ((IDX_W > CP_W) ? IDX_W : CP_W) + 1;
  localparam int DW         = dmc_pkg::DIR_W;

  // remainder by three: base-4 digits sum up modulo three
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 4'(s[4:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
  endfunction

  // cell index to port width
  function automatic logic [CP_W-1:0] to_port(input logic [IDX_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[CP_W-1:0];
  endfunction

  dmc_pkg::dmc_state_t state_r, state_nxt;

  logic                 done_r;
  logic [CP_W-1:0]      start_cell_r;
  logic [1:0]           rnd_lo_r;
  logic [1:0]           rnd_m3_r;
  logic [IDX_W-1:0]     top_cell_r;
  logic [COL_W-1:0]     top_col_r;
  logic [ROW_W-1:0]     top_row_r;
  logic [DW-1:0]        probe_r;
  logic                 chk_r;
  logic [DW-1:0]        chk_dir_r;
  logic [3:0]           open_r;
  logic [IDX_W-1:0]     clr_addr_r;
  logic [COL_W-1:0]     clr_col_r;
  logic [ROW_W-1:0]     clr_row_r;
  logic [COL_W-1:0]     start_col_r;
  logic [ROW_W-1:0]     start_row_r;
  logic                 res_edge_r;
  logic                 res_fin_r;
  logic [CP_W-1:0]      res_from_r;
  logic [DW-1:0]        res_dir_r;
  logic [CP_W-1:0]      res_to_r;
  logic                 out_valid_r;
  logic [dmc_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]           out_user_r;

  logic                 in_acc;
  logic                 out_load;
  logic                 clr_last;
  logic                 run_empty;
  logic [IDX_W-1:0]     start_idx;
  logic [CMP_W-1:0]     start_wide;
  logic [IDX_W-1:0]     nb_cell [4];
  logic [COL_W-1:0]     nb_col  [4];
  logic [ROW_W-1:0]     nb_row  [4];
  logic [3:0]           nb_ok;
  logic [2:0]           n_open;
  logic [1:0]           pick_k;
  logic [2:0]           cnt;
  logic [DW-1:0]        sel_dir;

  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == dmc_pkg::ST_RESULT) && (!out_valid_r || out_tready);
  assign clr_last  = (clr_addr_r == IDX_W'(CELL_COUNT - 1));
  assign run_empty = done_r || (stk_depth == '0);

  // start cell saturates to the last cell
  assign start_wide = CMP_W'(start_cell_r);
  assign start_idx  = (start_wide >= CMP_W'(CELL_COUNT)) ? IDX_W'(CELL_COUNT - 1)
                                                         : start_wide[IDX_W-1:0];

  // neighbors of the current stack top
  always_comb begin
    nb_cell[DW'(dmc_pkg::DIR_UP)]    = top_cell_r - IDX_W'(GRID_COLUMNS);
    nb_col[DW'(dmc_pkg::DIR_UP)]     = top_col_r;
    nb_row[DW'(dmc_pkg::DIR_UP)]     = top_row_r - ROW_W'(1);
    nb_ok[dmc_pkg::DIR_UP]           = (top_row_r != '0);
    nb_cell[DW'(dmc_pkg::DIR_RIGHT)] = top_cell_r + IDX_W'(1);
    nb_col[DW'(dmc_pkg::DIR_RIGHT)]  = top_col_r + COL_W'(1);
    nb_row[DW'(dmc_pkg::DIR_RIGHT)]  = top_row_r;
    nb_ok[dmc_pkg::DIR_RIGHT]        = (top_col_r != COL_W'(GRID_COLUMNS - 1));
    nb_cell[DW'(dmc_pkg::DIR_DOWN)]  = top_cell_r + IDX_W'(GRID_COLUMNS);
    nb_col[DW'(dmc_pkg::DIR_DOWN)]   = top_col_r;
    nb_row[DW'(dmc_pkg::DIR_DOWN)]   = top_row_r + ROW_W'(1);
    nb_ok[dmc_pkg::DIR_DOWN]         = (top_row_r != ROW_W'(GRID_ROWS - 1));
    nb_cell[DW'(dmc_pkg::DIR_LEFT)]  = top_cell_r - IDX_W'(1);
    nb_col[DW'(dmc_pkg::DIR_LEFT)]   = top_col_r - COL_W'(1);
    nb_row[DW'(dmc_pkg::DIR_LEFT)]   = top_row_r;
    nb_ok[dmc_pkg::DIR_LEFT]         = (top_col_r != '0);
  end

  // count open neighbors and pick one by the random value
  always_comb begin
    n_open = 3'(open_r[0]) + 3'(open_r[1]) + 3'(open_r[2]) + 3'(open_r[3]);
    case (n_open)
      3'd2:    pick_k = {1'b0, rnd_lo_r[0]};
      3'd3:    pick_k = rnd_m3_r;
      3'd4:    pick_k = rnd_lo_r;
      default: pick_k = 2'd0;
    endcase
    cnt     = '0;
    sel_dir = '0;
    for (int d = 0; d < 4; d++) begin
      if (open_r[d]) begin
        if (cnt == 3'(pick_k)) begin
          sel_dir = DW'(d);
        end
        cnt = cnt + 3'd1;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmc_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == dmc_pkg::KIND_RESTART) begin
            state_nxt = dmc_pkg::ST_CLEAR;
          end else if (run_empty) begin
            state_nxt = dmc_pkg::ST_RESULT;
          end else begin
            state_nxt = dmc_pkg::ST_TOP_RD;
          end
        end
      end
      dmc_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = dmc_pkg::ST_START;
        end
      end
      dmc_pkg::ST_START:     state_nxt = dmc_pkg::ST_RESULT;
      dmc_pkg::ST_TOP_RD:    state_nxt = dmc_pkg::ST_TOP_LATCH;
      dmc_pkg::ST_TOP_LATCH: state_nxt = dmc_pkg::ST_PROBE;
      dmc_pkg::ST_PROBE: begin
        if (probe_r == dmc_pkg::DIR_LEFT) begin
          state_nxt = dmc_pkg::ST_SETTLE;
        end
      end
      dmc_pkg::ST_SETTLE:    state_nxt = dmc_pkg::ST_PICK;
      dmc_pkg::ST_PICK: begin
        if (open_r != '0 || stk_depth == DEPTH_W'(1)) begin
          state_nxt = dmc_pkg::ST_RESULT;
        end else begin
          state_nxt = dmc_pkg::ST_TOP_RD;
        end
      end
      dmc_pkg::ST_RESULT: begin
        if (out_load) begin
          state_nxt = dmc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dmc_pkg::ST_IDLE;
    endcase
  end

  // memory requests and handshake outputs
  always_comb begin
    in_tready  = (state_r == dmc_pkg::ST_IDLE);
    vis_ctl    = '0;
    vis_addr   = clr_addr_r;
    stk_ctl    = '0;
    stk_wentry = {nb_row[sel_dir], nb_col[sel_dir], nb_cell[sel_dir]};
    case (state_r)
      dmc_pkg::ST_CLEAR: begin
        vis_ctl.wr = 1'b1;
      end
      dmc_pkg::ST_START: begin
        vis_ctl.wr      = 1'b1;
        vis_ctl.wbit    = 1'b1;
        vis_addr        = start_idx;
        stk_ctl.restart = 1'b1;
        stk_wentry      = {start_row_r, start_col_r, start_idx};
      end
      dmc_pkg::ST_TOP_RD: begin
        stk_ctl.rd = 1'b1;
      end
      dmc_pkg::ST_PROBE: begin
        vis_ctl.rd = nb_ok[probe_r];
        vis_addr   = nb_cell[probe_r];
      end
      dmc_pkg::ST_PICK: begin
        if (open_r != '0) begin
          vis_ctl.wr   = 1'b1;
          vis_ctl.wbit = 1'b1;
          vis_addr     = nb_cell[sel_dir];
          stk_ctl.push = 1'b1;
        end else begin
          stk_ctl.pop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dmc_pkg::ST_IDLE;
      done_r       <= 1'b1;
      start_cell_r <= '0;
      out_valid_r  <= 1'b0;
      chk_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_r   <= (state_r == dmc_pkg::ST_PROBE) && nb_ok[probe_r];
      if (cfg_we) begin
        start_cell_r <= cfg_wdata;
      end
      if (state_r == dmc_pkg::ST_START) begin
        done_r <= 1'b0;
      end else if (state_r == dmc_pkg::ST_IDLE && in_acc &&
                   in_tuser == dmc_pkg::KIND_STEP && run_empty) begin
        done_r <= 1'b1;
      end else if (state_r == dmc_pkg::ST_PICK && open_r == '0 &&
                   stk_depth == DEPTH_W'(1)) begin
        done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rnd_lo_r <= in_tdata[1:0];
      rnd_m3_r <= mod3_16(in_tdata);
    end

    // clearing sweep walks column and row along the address
    if (state_r == dmc_pkg::ST_IDLE) begin
      clr_addr_r <= '0;
      clr_col_r  <= '0;
      clr_row_r  <= '0;
    end else if (state_r == dmc_pkg::ST_CLEAR) begin
      clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (clr_col_r == COL_W'(GRID_COLUMNS - 1)) begin
        clr_col_r <= '0;
        clr_row_r <= clr_row_r + ROW_W'(1);
      end else begin
        clr_col_r <= clr_col_r + COL_W'(1);
      end
      if (clr_addr_r == start_idx) begin
        start_col_r <= clr_col_r;
        start_row_r <= clr_row_r;
      end
    end

    // neighbor probe results land in open_r from the registered read data, flagged by chk_r
    if (chk_r) begin
      open_r[chk_dir_r] <= !vis_rdata;
    end
    if (state_r == dmc_pkg::ST_TOP_LATCH) begin
      {top_row_r, top_col_r, top_cell_r} <= stk_rentry;
      open_r  <= '0;
      probe_r <= dmc_pkg::DIR_UP;
    end
    if (state_r == dmc_pkg::ST_PROBE) begin
      chk_dir_r <= probe_r;
      probe_r   <= probe_r + DW'(1);
    end

    // result fields
    if (state_r == dmc_pkg::ST_IDLE) begin
      res_edge_r <= 1'b0;
      res_fin_r  <= 1'b1;
      res_from_r <= '0;
      res_dir_r  <= '0;
      res_to_r   <= '0;
    end else if (state_r == dmc_pkg::ST_START) begin
      res_fin_r <= 1'b0;
    end else if (state_r == dmc_pkg::ST_PICK && open_r != '0) begin
      res_edge_r <= 1'b1;
      res_fin_r  <= 1'b0;
      res_from_r <= to_port(top_cell_r);
      res_dir_r  <= sel_dir;
      res_to_r   <= to_port(nb_cell[sel_dir]);
    end

    if (out_load) begin
      out_data_r <= {res_to_r, res_dir_r, res_from_r};
      out_user_r <= {res_fin_r, res_edge_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // the walk only starts on a live maze
  a_walk_live: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == dmc_pkg::ST_TOP_RD |-> !done_r && stk_depth != '0)
    else $error("walk started without a maze in progress");

  // the chosen direction is one of the open neighbors
  a_pick_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dmc_pkg::ST_PICK && open_r != '0) |-> open_r[sel_dir])
    else $error("picked a closed neighbor");

  // a carved edge never comes together with the finished flag
  a_edge_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_user_r[0] && out_user_r[1]))
    else $error("edge and finished in one result");

  // a finished result leaves no maze in progress
  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_fin_r) |=> done_r)
    else $error("finished reported while a maze is in progress");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // full-size grid as the block is built by default
  localparam int COLS         = dmc_pkg::GRID_COLUMNS_DEF;
  localparam int ROWS         = dmc_pkg::GRID_ROWS_DEF;
  localparam int CELLS        = COLS * ROWS;
  localparam int CELL_W       = dmc_pkg::CELL_PORT_W;
  localparam int RND_W        = dmc_pkg::RND_W;
  localparam int DIR_W        = dmc_pkg::DIR_W;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 300;
  localparam int START_MAX    = (1 << CELL_W) - 1;

  // one expected result
  typedef struct packed {
    logic              carved;
    logic [CELL_W-1:0] src_cell;
    logic [DIR_W-1:0]  wall_dir;
    logic [CELL_W-1:0] dst_cell;
    logic              complete;
  } carve_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [dmc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;   // random_value
  logic [0:0]                      in_tuser = '0;   // kind
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [dmc_pkg::OUT_TDATA_W-1:0] out_tdata;       // from_cell, direction, to_cell
  logic [1:0]                      out_tuser;       // edge_valid, finished
  logic                            cfg_we = 1'b0;
  logic [CELL_W-1:0]               cfg_wdata = '0;  // start_cell

  // maze state as the block should hold it
  bit                     visited_cells [CELLS];
  int                     carve_path [CELLS];
  int                     carve_depth = 0;
  bit                     maze_open = 1'b0;
  int                     start_reg = 0;

  carve_result_t          pending_carves [$];

  int                     fail_count = 0;
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     stall_left = 0;
  int                     restarts_sent = 0;
  int                     steps_sent = 0;
  int                     passages_seen = 0;
  int                     mazes_done = 0;

  dfs_maze_carver_top #(
    .GRID_COLUMNS(COLS),
    .GRID_ROWS   (ROWS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // next carving result, advancing the expected maze state
  function automatic carve_result_t predict_carve(input logic kind,
                                                  input logic [RND_W-1:0] rnd);
    carve_result_t    res;
    int               seed_cell;
    int               top;
    int               col;
    int               row;
    int               n_open;
    int               pick;
    int               open_cell [4];
    logic [DIR_W-1:0] open_dir [4];
    res = '0;
    if (kind == dmc_pkg::KIND_RESTART) begin
      seed_cell = (start_reg >= CELLS) ? CELLS - 1 : start_reg;
      foreach (visited_cells[i]) visited_cells[i] = 1'b0;
      visited_cells[seed_cell] = 1'b1;
      carve_path[0] = seed_cell;
      carve_depth = 1;
      maze_open = 1'b1;
      return res;
    end
    while (maze_open && carve_depth > 0) begin
      top = carve_path[carve_depth - 1];
      col = top % COLS;
      row = top / COLS;
      n_open = 0;
      // neighbours in the order up, right, down, left
      if (row > 0 && !visited_cells[top - COLS]) begin
        open_cell[n_open] = top - COLS;
        open_dir[n_open] = dmc_pkg::DIR_UP;
        n_open++;
      end
      if (col + 1 < COLS && !visited_cells[top + 1]) begin
        open_cell[n_open] = top + 1;
        open_dir[n_open] = dmc_pkg::DIR_RIGHT;
        n_open++;
      end
      if (row + 1 < ROWS && !visited_cells[top + COLS]) begin
        open_cell[n_open] = top + COLS;
        open_dir[n_open] = dmc_pkg::DIR_DOWN;
        n_open++;
      end
      if (col > 0 && !visited_cells[top - 1]) begin
        open_cell[n_open] = top - 1;
        open_dir[n_open] = dmc_pkg::DIR_LEFT;
        n_open++;
      end
      // dead end: backtrack
      if (n_open == 0) begin
        carve_depth--;
        continue;
      end
      pick = int'(rnd) % n_open;
      visited_cells[open_cell[pick]] = 1'b1;
      carve_path[carve_depth] = open_cell[pick];
      carve_depth++;
      res.carved = 1'b1;
      res.src_cell = CELL_W'(top);
      res.wall_dir = open_dir[pick];
      res.dst_cell = CELL_W'(open_cell[pick]);
      return res;
    end
    // stack ran empty, or no maze in progress
    carve_depth = 0;
    maze_open = 1'b0;
    res.complete = 1'b1;
    return res;
  endfunction

  // offer one request and wait until it is taken
  task automatic send_request(input logic kind, input logic [RND_W-1:0] rnd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= rnd;
    do @(posedge clk); while (!in_tready);
    pending_carves.push_back(predict_carve(kind, rnd));
    if (kind == dmc_pkg::KIND_RESTART) restarts_sent++;
    else steps_sent++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_carves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(input logic [CELL_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    start_reg = value;
  endtask

  function automatic logic [RND_W-1:0] pick_random();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return RND_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] pick_start();
    if ($urandom_range(99) < 75) return CELL_W'($urandom_range(0, CELLS - 1));
    return CELL_W'($urandom_range(CELLS, START_MAX));
  endfunction

  // steps before any restart must report a finished maze
  task automatic test_step_without_maze();
    send_request(dmc_pkg::KIND_STEP, '0);
    send_request(dmc_pkg::KIND_STEP, '1);
  endtask

  // corners, saturating start values and a full four-way choice
  task automatic test_start_cells();
    int starts [6];
    starts = '{0, COLS - 1, CELLS - COLS, CELLS - 1, CELLS, START_MAX};
    foreach (starts[i]) begin
      wait_drained();
      write_start(CELL_W'(starts[i]));
      send_request(dmc_pkg::KIND_RESTART, RND_W'($urandom_range(0, 65535)));
      send_request(dmc_pkg::KIND_STEP, '0);
      send_request(dmc_pkg::KIND_STEP, '1);
    end
    wait_drained();
    write_start(CELL_W'(3 * COLS + 4));
    send_request(dmc_pkg::KIND_RESTART, '0);
    send_request(dmc_pkg::KIND_STEP, 16'd1);
    send_request(dmc_pkg::KIND_STEP, 16'd2);
    send_request(dmc_pkg::KIND_STEP, 16'd3);
  endtask

  // long carving runs with random choices, some stray steps and early restarts
  task automatic test_random_carving(input int count, input int s_pct, input int r_pct);
    logic kind;
    wait_drained();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    write_start(pick_start());
    for (int i = 0; i < count; i++) begin
      if (i % 120 == 119) begin
        wait_drained();
        write_start(pick_start());
      end
      if (!maze_open) begin
        kind = ($urandom_range(99) < 80) ? dmc_pkg::KIND_RESTART : dmc_pkg::KIND_STEP;
      end else begin
        kind = ($urandom_range(99) < 2) ? dmc_pkg::KIND_RESTART : dmc_pkg::KIND_STEP;
      end
      send_request(kind, pick_random());
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits it out
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(dmc_pkg::KIND_RESTART, pick_random());
    wait_drained();
    stall_left = LONG_STALL;
    for (int i = 0; i < 24; i++) send_request(dmc_pkg::KIND_STEP, pick_random());
    wait_drained();
  endtask

  // result sink with random and long stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each result against the oldest expectation
  always @(posedge clk) begin
    carve_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_carves.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b", out_tdata, out_tuser);
        fail_count++;
      end else begin
        want = pending_carves.pop_front();
        if (out_tuser[0] !== want.carved) begin
          $error("edge_valid: expected %0d, got %0d", want.carved, out_tuser[0]);
          fail_count++;
        end
        if (out_tdata[10:0] !== want.src_cell) begin
          $error("from_cell: expected %0d, got %0d", want.src_cell, out_tdata[10:0]);
          fail_count++;
        end
        if (out_tdata[12:11] !== want.wall_dir) begin
          $error("direction: expected %0d, got %0d", want.wall_dir, out_tdata[12:11]);
          fail_count++;
        end
        if (out_tdata[23:13] !== want.dst_cell) begin
          $error("to_cell: expected %0d, got %0d", want.dst_cell, out_tdata[23:13]);
          fail_count++;
        end
        if (out_tuser[1] !== want.complete) begin
          $error("finished: expected %0d, got %0d", want.complete, out_tuser[1]);
          fail_count++;
        end
        if (want.carved) passages_seen++;
        if (want.complete) mazes_done++;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_step_without_maze();
    test_start_cells();
    test_random_carving(310, 18, 83);
    test_random_carving(310, 83, 18);
    test_backpressure();
    test_random_carving(310, 0, 0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_carves.size() != 0) begin
      $error("%0d expected results never arrived", pending_carves.size());
      fail_count++;
    end
    $display("covered %0d restarts and %0d steps: %0d passages carved, %0d finished results",
             restarts_sent, steps_sent, passages_seen, mazes_done);
    $display("start cells at corners, edges, saturating values and random; one %0d-cycle stall",
             LONG_STALL);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
